// ----- rtl/lazy_double_coverage_line_core_macros.svh -----
// Assertion macros shared by the lazy double coverage line core RTL.
`ifndef LAZY_DOUBLE_COVERAGE_LINE_CORE_MACROS_SVH
`define LAZY_DOUBLE_COVERAGE_LINE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every clock edge outside reset.
`define LDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never comes true outside reset.
`define LDC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LDC_ASSERT(lbl, prop, msg)
`define LDC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- rtl/ldc_pkg.sv -----
// Shared constants, types and helper functions for the lazy double coverage line core.
package ldc_pkg;

    localparam int SERVERS   = 4;
    localparam int LOCATIONS = 1024;

    localparam int SRV_W   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int POS_W   = 10;
    localparam int IDX_W   = 2;
    localparam int OUTC_W  = 2;
    localparam int TOTAL_W = 32;

    localparam logic [POS_W-1:0] LOC_MAX = POS_W'(LOCATIONS - 1);

    // Operation codes
    localparam logic OP_SERVE = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUT_COVERED   = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_VIRTUAL   = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_ONE_SIDED = 2'd2;
    localparam logic [OUTC_W-1:0] OUT_DOUBLE    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_WRITE,
        S_SHIFT,
        S_DONE
    } state_t;

    // Write port of the position file
    typedef struct packed {
        logic             real_en;
        logic             virt_en;
        logic [SRV_W-1:0] idx;
        logic [POS_W-1:0] value;
    } pos_wr_t;

    // Read data of the position file
    typedef struct packed {
        logic [POS_W-1:0] real_pos;
        logic [POS_W-1:0] virt_pos;
    } pos_rd_t;

    function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [POS_W-1:0] clamp_loc(input logic [POS_W-1:0] loc);
        return (int'(loc) > LOCATIONS - 1) ? LOC_MAX : loc;
    endfunction

endpackage

// ----- rtl/ldc_if.sv -----
// Valid/ready channel interfaces for request items and result items.
interface ldc_item_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [ldc_pkg::IDX_W-1:0]    server_index;
    logic [ldc_pkg::POS_W-1:0]    location;
    logic                         end_of_run;

    modport source (output valid, output operation, output server_index,
                    output location, output end_of_run, input ready);
    modport sink   (input valid, input operation, input server_index,
                    input location, input end_of_run, output ready);
endinterface

interface ldc_result_if;
    logic                         valid;
    logic                         ready;
    logic [ldc_pkg::POS_W-1:0]    step_cost;
    logic [ldc_pkg::TOTAL_W-1:0]  total_cost;
    logic [ldc_pkg::IDX_W-1:0]    served_by;
    logic [ldc_pkg::OUTC_W-1:0]   outcome;

    modport source (output valid, output step_cost, output total_cost,
                    output served_by, output outcome, input ready);
    modport sink   (input valid, input step_cost, input total_cost,
                    input served_by, input outcome, output ready);
endinterface

// ----- rtl/ldc_posfile.sv -----
// Real and virtual server position file: one read port, one write port.
module ldc_posfile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ldc_pkg::SRV_W-1:0]   rd_idx,
    output ldc_pkg::pos_rd_t            rd,
    input  ldc_pkg::pos_wr_t            wr
);

    logic [ldc_pkg::POS_W-1:0] real_reg [ldc_pkg::SERVERS];
    logic [ldc_pkg::POS_W-1:0] virt_reg [ldc_pkg::SERVERS];

    // Clear all servers to location zero, then write one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ldc_pkg::SERVERS; i++)
            begin
                real_reg[i] <= '0;
                virt_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.real_en)
            begin
                real_reg[wr.idx] <= wr.value;
            end
            if (wr.virt_en)
            begin
                virt_reg[wr.idx] <= wr.value;
            end
        end
    end

    // Read the scanned server
    assign rd.real_pos = real_reg[rd_idx];
    assign rd.virt_pos = virt_reg[rd_idx];

endmodule

// ----- rtl/lazy_double_coverage_line_core.sv -----
// Place request: after acceptance the core writes the position file (WRITE), then loads the result (DONE).
// Serve request: the core scans the servers (SCAN), decides the move (CALC) and writes (WRITE),
// with a virtual shift (SHIFT) for a double coverage move; the position scan visits one server per cycle.
// A new request is taken the cycle after the result is loaded into the output register,
// and the core waits in DONE while the output register still holds an untaken result.
// Reset clears all real and virtual positions, the running total and the output valid.
`include "lazy_double_coverage_line_core_macros.svh"

module lazy_double_coverage_line_core (
    input  logic          clk,
    input  logic          rst_n,
    ldc_item_if.sink      item,
    ldc_result_if.source  result
);

    localparam int SRV_W   = ldc_pkg::SRV_W;
    localparam int POS_W   = ldc_pkg::POS_W;
    localparam int IDX_W   = ldc_pkg::IDX_W;
    localparam int OUTC_W  = ldc_pkg::OUTC_W;
    localparam int TOTAL_W = ldc_pkg::TOTAL_W;

    ldc_pkg::state_t state_reg, state_next;

    logic [SRV_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               eor_reg, eor_next;
    logic [POS_W-1:0]   loc_reg, loc_next;

    // Scan results
    logic               rhit_found_reg, rhit_found_next;
    logic [SRV_W-1:0]   rhit_idx_reg, rhit_idx_next;
    logic               vhit_found_reg, vhit_found_next;
    logic [SRV_W-1:0]   vhit_idx_reg, vhit_idx_next;
    logic [POS_W-1:0]   vhit_real_reg, vhit_real_next;
    logic               left_found_reg, left_found_next;
    logic [SRV_W-1:0]   left_idx_reg, left_idx_next;
    logic [POS_W-1:0]   left_dist_reg, left_dist_next;
    logic [POS_W-1:0]   left_real_reg, left_real_next;
    logic               right_found_reg, right_found_next;
    logic [SRV_W-1:0]   right_idx_reg, right_idx_next;
    logic [POS_W-1:0]   right_dist_reg, right_dist_next;
    logic [POS_W-1:0]   right_real_reg, right_real_next;

    // Decision
    logic [POS_W-1:0]   cost_reg, cost_next;
    logic [SRV_W-1:0]   serve_idx_reg, serve_idx_next;
    logic [IDX_W-1:0]   served_by_reg, served_by_next;
    logic [OUTC_W-1:0]  outcome_reg, outcome_next;
    logic               wr_real_reg, wr_real_next;
    logic               wr_virt_reg, wr_virt_next;
    logic               shift_reg, shift_next;
    logic [SRV_W-1:0]   other_idx_reg, other_idx_next;
    logic [POS_W-1:0]   shift_val_reg, shift_val_next;

    logic [TOTAL_W-1:0] total_reg, total_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_cost_reg, out_cost_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic [IDX_W-1:0]   out_served_reg, out_served_next;
    logic [OUTC_W-1:0]  out_outcome_reg, out_outcome_next;

    logic               accept;
    logic               out_load;
    ldc_pkg::pos_rd_t   rd;
    ldc_pkg::pos_wr_t   wr;

    ldc_posfile u_posfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (scan_cnt_reg),
        .rd     (rd),
        .wr     (wr)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ldc_pkg::S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = (item.operation == ldc_pkg::OP_PLACE) ?
                                 ldc_pkg::S_WRITE : ldc_pkg::S_SCAN;
                end
            end
            ldc_pkg::S_SCAN:
            begin
                if (scan_cnt_reg == SRV_W'(ldc_pkg::SERVERS - 1))
                begin
                    state_next = ldc_pkg::S_CALC;
                end
            end
            ldc_pkg::S_CALC:
            begin
                state_next = ldc_pkg::S_WRITE;
            end
            ldc_pkg::S_WRITE:
            begin
                state_next = shift_reg ? ldc_pkg::S_SHIFT : ldc_pkg::S_DONE;
            end
            ldc_pkg::S_SHIFT:
            begin
                state_next = ldc_pkg::S_DONE;
            end
            ldc_pkg::S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ldc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ldc_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs: handshake, position file write port, output load
    always_comb
    begin
        item.ready = 1'b0;
        out_load   = 1'b0;
        wr         = '0;
        case (state_reg)
            ldc_pkg::S_IDLE:
            begin
                item.ready = 1'b1;
            end
            ldc_pkg::S_WRITE:
            begin
                wr.real_en = wr_real_reg;
                wr.virt_en = wr_virt_reg;
                wr.idx     = serve_idx_reg;
                wr.value   = loc_reg;
            end
            ldc_pkg::S_SHIFT:
            begin
                wr.virt_en = 1'b1;
                wr.idx     = other_idx_reg;
                wr.value   = shift_val_reg;
            end
            ldc_pkg::S_DONE:
            begin
                out_load = !out_valid_reg || result.ready;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    assign accept = item.valid && item.ready;

    // Datapath: latch request, scan servers, decide the move, update the total
    always_comb
    begin
        logic [POS_W-1:0]   loc_c;
        logic [POS_W-1:0]   gap;
        logic [POS_W-1:0]   drl;
        logic [POS_W-1:0]   drr;
        logic               left_wins;
        logic [POS_W:0]     shifted;
        logic [TOTAL_W:0]   sum;

        loc_c     = ldc_pkg::clamp_loc(item.location);
        gap       = '0;
        drl       = ldc_pkg::abs_diff(left_real_reg, loc_reg);
        drr       = ldc_pkg::abs_diff(right_real_reg, loc_reg);
        left_wins = (left_dist_reg < right_dist_reg) ||
                    ((left_dist_reg == right_dist_reg) && (drl < drr));
        shifted   = {1'b0, loc_reg} + {1'b0, right_dist_reg} - {1'b0, left_dist_reg};
        sum       = {1'b0, total_reg} + (TOTAL_W + 1)'(cost_reg);

        scan_cnt_next    = scan_cnt_reg;
        eor_next         = eor_reg;
        loc_next         = loc_reg;
        rhit_found_next  = rhit_found_reg;
        rhit_idx_next    = rhit_idx_reg;
        vhit_found_next  = vhit_found_reg;
        vhit_idx_next    = vhit_idx_reg;
        vhit_real_next   = vhit_real_reg;
        left_found_next  = left_found_reg;
        left_idx_next    = left_idx_reg;
        left_dist_next   = left_dist_reg;
        left_real_next   = left_real_reg;
        right_found_next = right_found_reg;
        right_idx_next   = right_idx_reg;
        right_dist_next  = right_dist_reg;
        right_real_next  = right_real_reg;
        cost_next        = cost_reg;
        serve_idx_next   = serve_idx_reg;
        served_by_next   = served_by_reg;
        outcome_next     = outcome_reg;
        wr_real_next     = wr_real_reg;
        wr_virt_next     = wr_virt_reg;
        shift_next       = shift_reg;
        other_idx_next   = other_idx_reg;
        shift_val_next   = shift_val_reg;
        total_next       = total_reg;

        case (state_reg)
            ldc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    loc_next         = loc_c;
                    eor_next         = item.end_of_run;
                    scan_cnt_next    = '0;
                    rhit_found_next  = 1'b0;
                    vhit_found_next  = 1'b0;
                    left_found_next  = 1'b0;
                    right_found_next = 1'b0;
                    shift_next       = 1'b0;
                    cost_next        = '0;
                    outcome_next     = ldc_pkg::OUT_COVERED;
                    served_by_next   = item.server_index;
                    serve_idx_next   = SRV_W'(item.server_index);
                    // Place writes only an existing server
                    wr_real_next     = (item.operation == ldc_pkg::OP_PLACE) &&
                                       (int'(item.server_index) < ldc_pkg::SERVERS);
                    wr_virt_next     = wr_real_next;
                end
            end
            ldc_pkg::S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + SRV_W'(1);
                // First real and virtual match, lowest index wins
                if (!rhit_found_reg && rd.real_pos == loc_reg)
                begin
                    rhit_found_next = 1'b1;
                    rhit_idx_next   = scan_cnt_reg;
                end
                if (!vhit_found_reg && rd.virt_pos == loc_reg)
                begin
                    vhit_found_next = 1'b1;
                    vhit_idx_next   = scan_cnt_reg;
                    vhit_real_next  = rd.real_pos;
                end
                // Nearest virtual server on each side, strict compare keeps lowest index
                if (rd.virt_pos < loc_reg)
                begin
                    gap = loc_reg - rd.virt_pos;
                    if (!left_found_reg || gap < left_dist_reg)
                    begin
                        left_found_next = 1'b1;
                        left_idx_next   = scan_cnt_reg;
                        left_dist_next  = gap;
                        left_real_next  = rd.real_pos;
                    end
                end
                else if (rd.virt_pos > loc_reg)
                begin
                    gap = rd.virt_pos - loc_reg;
                    if (!right_found_reg || gap < right_dist_reg)
                    begin
                        right_found_next = 1'b1;
                        right_idx_next   = scan_cnt_reg;
                        right_dist_next  = gap;
                        right_real_next  = rd.real_pos;
                    end
                end
            end
            ldc_pkg::S_CALC:
            begin
                shift_next = 1'b0;
                if (rhit_found_reg)
                begin
                    cost_next      = '0;
                    serve_idx_next = rhit_idx_reg;
                    outcome_next   = ldc_pkg::OUT_COVERED;
                    wr_real_next   = 1'b0;
                    wr_virt_next   = 1'b0;
                end
                else if (vhit_found_reg)
                begin
                    cost_next      = ldc_pkg::abs_diff(vhit_real_reg, loc_reg);
                    serve_idx_next = vhit_idx_reg;
                    outcome_next   = ldc_pkg::OUT_VIRTUAL;
                    wr_real_next   = 1'b1;
                    wr_virt_next   = 1'b0;
                end
                else if (!left_found_reg || !right_found_reg)
                begin
                    cost_next      = left_found_reg ? drl : drr;
                    serve_idx_next = left_found_reg ? left_idx_reg : right_idx_reg;
                    outcome_next   = ldc_pkg::OUT_ONE_SIDED;
                    wr_real_next   = 1'b1;
                    wr_virt_next   = 1'b1;
                end
                else
                begin
                    // Nearer side serves; far virtual server closes by the same distance
                    cost_next      = left_wins ? drl : drr;
                    serve_idx_next = left_wins ? left_idx_reg : right_idx_reg;
                    other_idx_next = left_wins ? right_idx_reg : left_idx_reg;
                    shift_val_next = shifted[POS_W-1:0];
                    shift_next     = 1'b1;
                    outcome_next   = ldc_pkg::OUT_DOUBLE;
                    wr_real_next   = 1'b1;
                    wr_virt_next   = 1'b1;
                end
                served_by_next = IDX_W'(serve_idx_next);
            end
            ldc_pkg::S_WRITE:
            begin
                // Saturating add of the step cost
                total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            end
            ldc_pkg::S_DONE:
            begin
                if (out_load && eor_reg)
                begin
                    total_next = '0;
                end
            end
            default:
            begin
                total_next = total_reg;
            end
        endcase
    end

    // Output register: load on completion, drop once taken
    always_comb
    begin
        out_valid_next   = out_valid_reg && !result.ready;
        out_cost_next    = out_cost_reg;
        out_total_next   = out_total_reg;
        out_served_next  = out_served_reg;
        out_outcome_next = out_outcome_reg;
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            out_cost_next    = cost_reg;
            out_total_next   = total_reg;
            out_served_next  = served_by_reg;
            out_outcome_next = outcome_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ldc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            scan_cnt_reg  <= '0;
            shift_reg     <= 1'b0;
            wr_real_reg   <= 1'b0;
            wr_virt_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            scan_cnt_reg  <= scan_cnt_next;
            shift_reg     <= shift_next;
            wr_real_reg   <= wr_real_next;
            wr_virt_reg   <= wr_virt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        eor_reg         <= eor_next;
        loc_reg         <= loc_next;
        rhit_found_reg  <= rhit_found_next;
        rhit_idx_reg    <= rhit_idx_next;
        vhit_found_reg  <= vhit_found_next;
        vhit_idx_reg    <= vhit_idx_next;
        vhit_real_reg   <= vhit_real_next;
        left_found_reg  <= left_found_next;
        left_idx_reg    <= left_idx_next;
        left_dist_reg   <= left_dist_next;
        left_real_reg   <= left_real_next;
        right_found_reg <= right_found_next;
        right_idx_reg   <= right_idx_next;
        right_dist_reg  <= right_dist_next;
        right_real_reg  <= right_real_next;
        cost_reg        <= cost_next;
        serve_idx_reg   <= serve_idx_next;
        served_by_reg   <= served_by_next;
        outcome_reg     <= outcome_next;
        other_idx_reg   <= other_idx_next;
        shift_val_reg   <= shift_val_next;
        out_cost_reg    <= out_cost_next;
        out_total_reg   <= out_total_next;
        out_served_reg  <= out_served_next;
        out_outcome_reg <= out_outcome_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.step_cost  = out_cost_reg;
    assign result.total_cost = out_total_reg;
    assign result.served_by  = out_served_reg;
    assign result.outcome    = out_outcome_reg;

    `LDC_ASSERT(a_busy_after_accept, accept |=> !item.ready, "ready high right after accepting a request")
    `LDC_ASSERT(a_covered_costs_nothing, result.valid && result.outcome == ldc_pkg::OUT_COVERED |-> result.step_cost == '0, "covered outcome with nonzero step cost")
    `LDC_ASSERT(a_shift_follows_write, state_reg == ldc_pkg::S_SHIFT |-> $past(state_reg) == ldc_pkg::S_WRITE, "virtual shift without a preceding write")
    `LDC_ASSERT_NEVER(a_scan_in_range, state_reg == ldc_pkg::S_SCAN && int'(scan_cnt_reg) >= ldc_pkg::SERVERS, "scan index beyond last server")

endmodule

// ----- tb/tb_lazy_double_coverage_line_core.sv -----
// Self-checking testbench for the lazy double coverage line core.
module tb_lazy_double_coverage_line_core;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_PCT     = 38;
    localparam int CHOKE_CYCLES = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SCRIPT_ROWS  = 20;

    // One request as offered to the block
    typedef struct packed {
        logic                      operation;
        logic [ldc_pkg::IDX_W-1:0] server_index;
        logic [ldc_pkg::POS_W-1:0] location;
        logic                      end_of_run;
    } line_req_t;

    // One result as reported by the block
    typedef struct packed {
        logic [ldc_pkg::POS_W-1:0]   step_cost;
        logic [ldc_pkg::TOTAL_W-1:0] total_cost;
        logic [ldc_pkg::IDX_W-1:0]   served_by;
        logic [ldc_pkg::OUTC_W-1:0]  outcome;
    } cost_report_t;

    // Directed row: request, plus a typed-in result where it is obvious
    typedef struct packed {
        line_req_t    rq;
        logic         known;
        cost_report_t rep;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        // all servers start at zero: request at zero is already covered
        '{'{ldc_pkg::OP_SERVE, 2'd2, 10'd0,    1'b0}, 1'b1,
          '{10'd0,    32'd0,    2'd0, ldc_pkg::OUT_COVERED}},
        // far end with every server on the left: lowest one walks the whole line
        '{'{ldc_pkg::OP_SERVE, 2'd1, 10'd1023, 1'b0}, 1'b1,
          '{10'd1023, 32'd1023, 2'd0, ldc_pkg::OUT_ONE_SIDED}},
        // place shows the total, then end of run clears it
        '{'{ldc_pkg::OP_PLACE, 2'd3, 10'd1023, 1'b1}, 1'b1,
          '{10'd0,    32'd1023, 2'd3, ldc_pkg::OUT_COVERED}},
        '{'{ldc_pkg::OP_PLACE, 2'd1, 10'd512,  1'b0}, 1'b1,
          '{10'd0,    32'd0,    2'd1, ldc_pkg::OUT_COVERED}},
        '{'{ldc_pkg::OP_PLACE, 2'd2, 10'd300,  1'b0}, 1'b1,
          '{10'd0,    32'd0,    2'd2, ldc_pkg::OUT_COVERED}},
        // two servers on one spot: lowest numbered covers it
        '{'{ldc_pkg::OP_SERVE, 2'd3, 10'd1023, 1'b0}, 1'b1,
          '{10'd0,    32'd0,    2'd0, ldc_pkg::OUT_COVERED}},
        // double coverage move, then a virtual hit on the dragged server
        '{'{ldc_pkg::OP_SERVE, 2'd0, 10'd400,  1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_SERVE, 2'd1, 10'd412,  1'b0}, 1'b0, '0},
        // nothing on the left of zero
        '{'{ldc_pkg::OP_SERVE, 2'd0, 10'd0,    1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_PLACE, 2'd0, 10'd100,  1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_PLACE, 2'd1, 10'd300,  1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_PLACE, 2'd2, 10'd700,  1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_PLACE, 2'd3, 10'd900,  1'b1}, 1'b0, '0},
        // equal virtual and real distance on both sides
        '{'{ldc_pkg::OP_SERVE, 2'd2, 10'd200,  1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_SERVE, 2'd3, 10'd1023, 1'b1}, 1'b0, '0},
        // equal distance within one side search
        '{'{ldc_pkg::OP_PLACE, 2'd0, 10'd5,    1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_PLACE, 2'd1, 10'd5,    1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_SERVE, 2'd1, 10'd6,    1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_SERVE, 2'd2, 10'd682,  1'b0}, 1'b0, '0},
        '{'{ldc_pkg::OP_SERVE, 2'd1, 10'd341,  1'b1}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    ldc_item_if   item_ch ();
    ldc_result_if result_ch ();

    lazy_double_coverage_line_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Predicted server state
    logic [ldc_pkg::POS_W-1:0]   actual_pos [ldc_pkg::SERVERS];
    logic [ldc_pkg::POS_W-1:0]   shadow_pos [ldc_pkg::SERVERS];
    logic [ldc_pkg::TOTAL_W-1:0] running_cost;

    cost_report_t cost_reports [$];
    int           mismatches;
    int           cycle_count;
    logic         steady;
    logic         choke_now;

    initial begin
        clk = 1'b0;
        for (int i = 0; i < ldc_pkg::SERVERS; i++)
        begin
            actual_pos[i] = '0;
            shadow_pos[i] = '0;
        end
        running_cost = '0;
        mismatches   = 0;
        cycle_count  = 0;
        steady       = 1'b0;
        choke_now    = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Apply one request to the predicted state and return the result it causes
    function automatic cost_report_t move_servers(input line_req_t rq);
        cost_report_t              rep;
        logic [ldc_pkg::POS_W-1:0] loc;
        int                        hit;
        int                        lft;
        int                        rgt;
        int                        pick;
        int                        moved;
        int                        dvl;
        int                        dvr;
        int                        drl;
        int                        drr;
        rep   = '0;
        moved = 0;
        loc   = (int'(rq.location) > ldc_pkg::LOCATIONS - 1) ?
                ldc_pkg::POS_W'(ldc_pkg::LOCATIONS - 1) : rq.location;
        if (rq.operation == ldc_pkg::OP_PLACE)
        begin
            if (int'(rq.server_index) < ldc_pkg::SERVERS)
            begin
                actual_pos[rq.server_index] = loc;
                shadow_pos[rq.server_index] = loc;
            end
            rep.served_by = rq.server_index;
            rep.outcome   = ldc_pkg::OUT_COVERED;
        end
        else
        begin
            hit = -1;
            for (int i = 0; i < ldc_pkg::SERVERS; i++)
                if (hit < 0 && actual_pos[i] == loc)
                    hit = i;
            if (hit >= 0)
            begin
                rep.served_by = ldc_pkg::IDX_W'(hit);
                rep.outcome   = ldc_pkg::OUT_COVERED;
            end
            else
            begin
                for (int i = 0; i < ldc_pkg::SERVERS; i++)
                    if (hit < 0 && shadow_pos[i] == loc)
                        hit = i;
                if (hit >= 0)
                begin
                    // virtual hit: only the real server catches up
                    moved = (actual_pos[hit] > loc) ? int'(actual_pos[hit]) - int'(loc)
                                                    : int'(loc) - int'(actual_pos[hit]);
                    actual_pos[hit] = loc;
                    rep.served_by   = ldc_pkg::IDX_W'(hit);
                    rep.outcome     = ldc_pkg::OUT_VIRTUAL;
                end
                else
                begin
                    // find nearest virtual server on each side, lowest index on ties
                    lft = -1;
                    rgt = -1;
                    for (int i = 0; i < ldc_pkg::SERVERS; i++)
                    begin
                        if (shadow_pos[i] < loc)
                        begin
                            if (lft < 0 || shadow_pos[i] > shadow_pos[lft])
                                lft = i;
                        end
                        else if (shadow_pos[i] > loc)
                        begin
                            if (rgt < 0 || shadow_pos[i] < shadow_pos[rgt])
                                rgt = i;
                        end
                    end
                    if (lft < 0 || rgt < 0)
                    begin
                        pick = (lft < 0) ? rgt : lft;
                        if (pick < 0)
                            pick = 0;
                        moved = (actual_pos[pick] > loc) ? int'(actual_pos[pick]) - int'(loc)
                                                         : int'(loc) - int'(actual_pos[pick]);
                        actual_pos[pick] = loc;
                        shadow_pos[pick] = loc;
                        rep.served_by    = ldc_pkg::IDX_W'(pick);
                        rep.outcome      = ldc_pkg::OUT_ONE_SIDED;
                    end
                    else
                    begin
                        dvl = int'(loc) - int'(shadow_pos[lft]);
                        dvr = int'(shadow_pos[rgt]) - int'(loc);
                        drl = (actual_pos[lft] > loc) ? int'(actual_pos[lft]) - int'(loc)
                                                      : int'(loc) - int'(actual_pos[lft]);
                        drr = (actual_pos[rgt] > loc) ? int'(actual_pos[rgt]) - int'(loc)
                                                      : int'(loc) - int'(actual_pos[rgt]);
                        // nearer virtual wins; real distance breaks a tie, else right
                        if (dvl < dvr || (dvl == dvr && drl < drr))
                        begin
                            moved           = drl;
                            actual_pos[lft] = loc;
                            shadow_pos[lft] = loc;
                            shadow_pos[rgt] = ldc_pkg::POS_W'(int'(shadow_pos[rgt]) - dvl);
                            rep.served_by   = ldc_pkg::IDX_W'(lft);
                        end
                        else
                        begin
                            moved           = drr;
                            actual_pos[rgt] = loc;
                            shadow_pos[rgt] = loc;
                            shadow_pos[lft] = ldc_pkg::POS_W'(int'(shadow_pos[lft]) + dvr);
                            rep.served_by   = ldc_pkg::IDX_W'(rgt);
                        end
                        rep.outcome = ldc_pkg::OUT_DOUBLE;
                    end
                end
            end
            // saturate the running total
            if (longint'(running_cost) + longint'(moved) > longint'(32'hFFFF_FFFF))
                running_cost = 32'hFFFF_FFFF;
            else
                running_cost = running_cost + ldc_pkg::TOTAL_W'(moved);
        end
        rep.step_cost  = (moved > 1023) ? ldc_pkg::POS_W'(1023) : ldc_pkg::POS_W'(moved);
        rep.total_cost = running_cost;
        if (rq.end_of_run)
            running_cost = '0;
        return rep;
    endfunction

    // Offer one request, hold it until taken, then record the expected result
    task automatic send_request(input line_req_t rq, input logic known,
                                input cost_report_t typed_rep);
        cost_report_t rep;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.operation    <= rq.operation;
        item_ch.server_index <= rq.server_index;
        item_ch.location     <= rq.location;
        item_ch.end_of_run   <= rq.end_of_run;
        do
            @(posedge clk);
        while (!item_ch.ready);
        rep = move_servers(rq);
        cost_reports = {cost_reports, (known ? typed_rep : rep)};
    endtask

    // Stimulus: reset, directed script, then random traffic
    initial begin
        line_req_t rq;
        int        pick;
        int        near;
        item_ch.valid        <= 1'b0;
        item_ch.operation    <= ldc_pkg::OP_SERVE;
        item_ch.server_index <= '0;
        item_ch.location     <= '0;
        item_ch.end_of_run   <= 1'b0;
        rst_n                <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[n])
            send_request(SCRIPT[n].rq, SCRIPT[n].known, SCRIPT[n].rep);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 150 && n < 230);
            if (n == 60)
                choke_now = 1'b1;
            rq.operation    = ($urandom_range(0, 99) < 15) ? ldc_pkg::OP_PLACE
                                                           : ldc_pkg::OP_SERVE;
            rq.server_index = ldc_pkg::IDX_W'($urandom_range(0, 3));
            rq.end_of_run   = ($urandom_range(0, 99) < 4);
            pick            = $urandom_range(0, 9);
            // aim most requests at or near where servers stand
            if (rq.operation == ldc_pkg::OP_SERVE && pick < 2)
                rq.location = actual_pos[$urandom_range(0, ldc_pkg::SERVERS - 1)];
            else if (rq.operation == ldc_pkg::OP_SERVE && pick < 4)
                rq.location = shadow_pos[$urandom_range(0, ldc_pkg::SERVERS - 1)];
            else if (pick < 7)
            begin
                near = int'(shadow_pos[$urandom_range(0, ldc_pkg::SERVERS - 1)])
                       + int'($urandom_range(0, 30)) - 15;
                if (near < 0)
                    near = 0;
                if (near > ldc_pkg::LOCATIONS - 1)
                    near = ldc_pkg::LOCATIONS - 1;
                rq.location = ldc_pkg::POS_W'(near);
            end
            else
                rq.location = ldc_pkg::POS_W'($urandom_range(0, ldc_pkg::LOCATIONS - 1));
            send_request(rq, 1'b0, '0);
        end
        steady        = 1'b0;
        item_ch.valid <= 1'b0;

        // drain outstanding results, then let the block settle
        while (cost_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_lazy_double_coverage_line_core: clean");
        else
            $display("tb_lazy_double_coverage_line_core: errors");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off, one calm stretch
    initial begin
        logic choke_done;
        choke_done = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (choke_now && !choke_done)
            begin
                choke_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
            end
            else
                result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        cost_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (cost_reports.size() == 0)
            begin
                $error("result with none expected: step_cost %0d total_cost %0d",
                       result_ch.step_cost, result_ch.total_cost);
                mismatches++;
            end
            else
            begin
                want = cost_reports.pop_front();
                if (result_ch.step_cost !== want.step_cost)
                begin
                    $error("step_cost: expected %0d, got %0d",
                           want.step_cost, result_ch.step_cost);
                    mismatches++;
                end
                if (result_ch.total_cost !== want.total_cost)
                begin
                    $error("total_cost: expected %0d, got %0d",
                           want.total_cost, result_ch.total_cost);
                    mismatches++;
                end
                if (result_ch.served_by !== want.served_by)
                begin
                    $error("served_by: expected %0d, got %0d",
                           want.served_by, result_ch.served_by);
                    mismatches++;
                end
                if (result_ch.outcome !== want.outcome)
                begin
                    $error("outcome: expected %0d, got %0d",
                           want.outcome, result_ch.outcome);
                    mismatches++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_lazy_double_coverage_line_core: errors");
            $finish;
        end
    end

endmodule
